/* design/msbox_pkg.sv */
`default_nettype none
package msbox_pkg;

    localparam logic [7:0] SBOX_CONST = 8'h63;
    localparam int SHARE_W = 8;
    localparam int MAX_SHARES = 3;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] t;
        r = 8'h00;
        t = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                r = r ^ t;
            end
            t = gf_xtime(t);
        end
        gf_mul = r;
    endfunction

    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        gf_sq = gf_mul(a, a);
    endfunction

    function automatic logic [7:0] lin_part(input logic [7:0] x);
        lin_part = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                   ^ {x[3:0], x[7:4]};
    endfunction

endpackage
`default_nettype wire

/* design/masked_aes_sbox.sv */
// Pipeline: from accepted request to result valid, four ISW product stages,
// then the output register.
// Throughput: one request per cycle; the five-stage share pipeline advances when the
// output register is empty or being taken.
// Reset: rst_n asynchronous, active low; clears all stage valid flags, results are
// discarded.
`default_nettype none
module masked_aes_sbox #(
    parameter int MASK_ORDER = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] in_shares,
    input  wire logic [63:0] rand_lo,
    input  wire logic [63:0] rand_hi,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      out_shares
);

    localparam int NSH   = MASK_ORDER + 1;
    localparam int SW    = NSH * 8;
    localparam int NPAIR = NSH * (NSH - 1) / 2;
    localparam int RW    = NPAIR * 8;
    localparam int RFW   = MASK_ORDER * 8;
    localparam int OFF_R1 = 0;
    localparam int OFF_M1 = RFW;
    localparam int OFF_R2 = OFF_M1 + RW;
    localparam int OFF_M2 = OFF_R2 + RFW;
    localparam int OFF_M3 = OFF_M2 + RW;
    localparam int OFF_M4 = OFF_M3 + RW;
    localparam int RTOT   = OFF_M4 + RW;

    logic [127:0] rbits;
    logic [255:0] rbits_x;
    logic         en;

    logic [SW-1:0] x_in;
    logic [SW-1:0] z0;
    logic [SW-1:0] z1_next;
    logic [SW-1:0] y1;
    logic [SW-1:0] w_next;
    logic [SW-1:0] y2;
    logic [SW-1:0] y2p;
    logic [SW-1:0] y3;
    logic [SW-1:0] y4;
    logic [SW-1:0] y_aff;
    logic          v1;
    logic          v2;
    logic          v3;
    logic          v4;

    logic [SW-1:0] z_s1_reg;
    logic [SW-1:0] z_s2_reg;
    logic [SW-1:0] z_s3_reg;
    logic [SW-1:0] w_s2_reg;
    logic [SW-1:0] w_s3_reg;
    logic [RTOT-1:0] r_s1_reg;
    logic [RTOT-1:0] r_s2_reg;
    logic [RTOT-1:0] r_s3_reg;
    logic [23:0]   out_reg;
    logic [23:0]   out_next;
    logic          ov_reg;

    assign rbits   = {rand_hi, rand_lo};
    assign rbits_x = {rbits, rbits};
    assign en      = !ov_reg || out_ready;
    assign in_ready = en;
    assign x_in    = in_shares[SW-1:0];

    always_comb
    begin
        for (int i = 0; i < NSH; i++)
        begin
            z0[8*i +: 8] = msbox_pkg::gf_sq(x_in[8*i +: 8]);
        end
        z1_next = z0;
        for (int i = 1; i < NSH; i++)
        begin
            z1_next[7:0]       = z1_next[7:0] ^ rbits_x[OFF_R1 + 8*(i-1) +: 8];
            z1_next[8*i +: 8]  = z1_next[8*i +: 8] ^ rbits_x[OFF_R1 + 8*(i-1) +: 8];
        end
    end

    msbox_isw_stage #(.NSH(NSH)) u_m1 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(in_valid && in_ready),
        .a(z1_next), .b(x_in), .rnd(rbits_x[OFF_M1 +: RW]), .vout(v1), .c(y1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_s1_reg <= z1_next;
            r_s1_reg <= rbits_x[RTOT-1:0];
            z_s2_reg <= z_s1_reg;
            r_s2_reg <= r_s1_reg;
            w_s2_reg <= w_next;
            z_s3_reg <= z_s2_reg;
            r_s3_reg <= r_s2_reg;
            w_s3_reg <= w_s2_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NSH; i++)
        begin
            w_next[8*i +: 8] = msbox_pkg::gf_sq(msbox_pkg::gf_sq(y1[8*i +: 8]));
        end
        for (int i = 1; i < NSH; i++)
        begin
            w_next[7:0]      = w_next[7:0] ^ r_s1_reg[OFF_R2 + 8*(i-1) +: 8];
            w_next[8*i +: 8] = w_next[8*i +: 8] ^ r_s1_reg[OFF_R2 + 8*(i-1) +: 8];
        end
    end

    msbox_isw_stage #(.NSH(NSH)) u_m2 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v1),
        .a(y1), .b(w_next), .rnd(r_s1_reg[OFF_M2 +: RW]), .vout(v2), .c(y2)
    );

    always_comb
    begin
        for (int i = 0; i < NSH; i++)
        begin
            y2p[8*i +: 8] = msbox_pkg::gf_sq(msbox_pkg::gf_sq(
                            msbox_pkg::gf_sq(msbox_pkg::gf_sq(y2[8*i +: 8]))));
        end
    end

    msbox_isw_stage #(.NSH(NSH)) u_m3 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v2),
        .a(y2p), .b(w_s2_reg), .rnd(r_s2_reg[OFF_M3 +: RW]), .vout(v3), .c(y3)
    );

    msbox_isw_stage #(.NSH(NSH)) u_m4 (
        .clk(clk), .rst_n(rst_n), .en(en), .vin(v3),
        .a(y3), .b(z_s3_reg), .rnd(r_s3_reg[OFF_M4 +: RW]), .vout(v4), .c(y4)
    );

    always_comb
    begin
        for (int i = 0; i < NSH; i++)
        begin
            y_aff[8*i +: 8] = msbox_pkg::lin_part(y4[8*i +: 8]) ^ msbox_pkg::SBOX_CONST;
        end
        if (MASK_ORDER % 2 == 1)
        begin
            y_aff[7:0] = y_aff[7:0] ^ msbox_pkg::SBOX_CONST;
        end
        out_next = 24'h0;
        out_next[SW-1:0] = y_aff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= v4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_shares = out_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_shares))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1)
        else $error("accepted request dropped");

endmodule
`default_nettype wire

/* design/msbox_isw_stage.sv */
`default_nettype none
module msbox_isw_stage #(
    parameter int NSH = 3
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    vin,
    input  wire logic [NSH*8-1:0]        a,
    input  wire logic [NSH*8-1:0]        b,
    input  wire logic [NSH*(NSH-1)*4-1:0] rnd,
    output logic                         vout,
    output logic [NSH*8-1:0]             c
);

    logic [NSH*8-1:0] prod_next;
    logic [NSH*8-1:0] c_reg;
    logic             v_reg;

    always_comb
    begin
        logic [7:0] acc [NSH];
        logic [7:0] rij;
        int p;
        p = 0;
        for (int i = 0; i < NSH; i++)
        begin
            acc[i] = msbox_pkg::gf_mul(a[8*i +: 8], b[8*i +: 8]);
        end
        for (int i = 0; i < NSH; i++)
        begin
            for (int j = i + 1; j < NSH; j++)
            begin
                rij = rnd[8*p +: 8];
                acc[i] = acc[i] ^ rij;
                acc[j] = acc[j] ^ rij ^ msbox_pkg::gf_mul(a[8*i +: 8], b[8*j +: 8])
                         ^ msbox_pkg::gf_mul(a[8*j +: 8], b[8*i +: 8]);
                p = p + 1;
            end
        end
        for (int i = 0; i < NSH; i++)
        begin
            prod_next[8*i +: 8] = acc[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= prod_next;
        end
    end

    assign vout = v_reg;
    assign c    = c_reg;

endmodule
`default_nettype wire

/* tb/sv/sbox_checker.sv */
`default_nettype none
module sbox_checker #(
    parameter int MASK_ORDER = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [23:0] in_shares,
    input  wire logic [63:0] rand_lo,
    input  wire logic [63:0] rand_hi,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [23:0] out_shares,
    output int               fail_count,
    output int               pending
);

    localparam int NSH = MASK_ORDER + 1;

    typedef logic [7:0] byte_t;
    typedef byte_t shares_t [msbox_pkg::MAX_SHARES];

    logic [23:0] sbox_queue[$];
    byte_t       rnd [16];
    int          rnd_pos;

    function automatic byte_t ff_mul(byte_t a, byte_t b);
        byte_t r;
        r = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return r;
    endfunction

    function automatic byte_t ff_pow2n(byte_t a, int n);
        for (int k = 0; k < n; k++)
            a = ff_mul(a, a);
        return a;
    endfunction

    function automatic byte_t next_rnd();
        byte_t v;
        v = rnd[rnd_pos & 15];
        rnd_pos++;
        return v;
    endfunction

    function automatic void remask(ref shares_t s);
        byte_t t;
        for (int i = 1; i < NSH; i++)
        begin
            t = next_rnd();
            s[0] ^= t;
            s[i] ^= t;
        end
    endfunction

    function automatic shares_t isw(shares_t a, shares_t b);
        byte_t   r [msbox_pkg::MAX_SHARES][msbox_pkg::MAX_SHARES];
        shares_t c;
        for (int i = 0; i < NSH; i++)
            for (int j = i + 1; j < NSH; j++)
            begin
                r[i][j] = next_rnd();
                r[j][i] = r[i][j] ^ ff_mul(a[i], b[j]) ^ ff_mul(a[j], b[i]);
            end
        for (int i = 0; i < msbox_pkg::MAX_SHARES; i++)
            c[i] = 8'h00;
        for (int i = 0; i < NSH; i++)
        begin
            c[i] = ff_mul(a[i], b[i]);
            for (int j = 0; j < NSH; j++)
                if (j != i)
                    c[i] ^= r[i][j];
        end
        return c;
    endfunction

    function automatic byte_t affine_lin(byte_t x);
        return x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]};
    endfunction

    function automatic logic [23:0] masked_sbox(logic [23:0] sh, logic [63:0] lo,
                                                logic [63:0] hi);
        shares_t     x, y, z, w;
        logic [23:0] packed_out;
        for (int i = 0; i < 8; i++)
        begin
            rnd[i]     = lo[8*i +: 8];
            rnd[8 + i] = hi[8*i +: 8];
        end
        rnd_pos = 0;
        for (int i = 0; i < msbox_pkg::MAX_SHARES; i++)
        begin
            x[i] = (i < NSH) ? sh[8*i +: 8] : 8'h00;
            z[i] = ff_pow2n(x[i], 1);
        end
        remask(z);
        y = isw(z, x);
        for (int i = 0; i < msbox_pkg::MAX_SHARES; i++)
            w[i] = ff_pow2n(y[i], 2);
        remask(w);
        y = isw(y, w);
        for (int i = 0; i < msbox_pkg::MAX_SHARES; i++)
            y[i] = ff_pow2n(y[i], 4);
        y = isw(y, w);
        y = isw(y, z);
        packed_out = 24'h0;
        for (int i = 0; i < NSH; i++)
        begin
            y[i] = affine_lin(y[i]) ^ msbox_pkg::SBOX_CONST;
            if (i == 0 && (MASK_ORDER % 2) == 1)
                y[i] ^= msbox_pkg::SBOX_CONST;
            packed_out[8*i +: 8] = y[i];
        end
        return packed_out;
    endfunction

    assign pending = sbox_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            sbox_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sbox_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %06h",
                             $time, out_shares);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (out_shares !== sbox_queue[0])
                    begin
                        $display("%0t: out_shares mismatch, expected %06h, actual %06h",
                                 $time, sbox_queue[0], out_shares);
                        fail_count <= fail_count + 1;
                    end
                    void'(sbox_queue.pop_front());
                end
            end
            if (in_valid && in_ready)
                sbox_queue.push_back(masked_sbox(in_shares, rand_lo, rand_hi));
        end
    end
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;
    localparam int MASK_ORDER = 2;
    localparam int N_RANDOM = 2000;
    localparam int WATCHDOG = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [23:0] in_shares;
    logic [63:0] rand_lo;
    logic [63:0] rand_hi;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] out_shares;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          stall_mode;

    masked_aes_sbox #(.MASK_ORDER(MASK_ORDER)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_shares(in_shares), .rand_lo(rand_lo), .rand_hi(rand_hi),
        .out_valid(out_valid), .out_ready(out_ready), .out_shares(out_shares)
    );

    sbox_checker #(.MASK_ORDER(MASK_ORDER)) chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_shares(in_shares), .rand_lo(rand_lo), .rand_hi(rand_hi),
        .out_valid(out_valid), .out_ready(out_ready), .out_shares(out_shares),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_shares = '0;
        rand_lo = '0;
        rand_hi = '0;
        out_ready = 1'b0;
        stall_mode = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern: phases of always ready, random, and mostly stalled
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(logic [23:0] sh, logic [63:0] lo, logic [63:0] hi);
        in_valid <= 1'b1;
        in_shares <= sh;
        rand_lo <= lo;
        rand_hi <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic hold_off(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        int burst;
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(24'h000000, 64'h0, 64'h0);
        send_request(24'hFFFFFF, 64'h0, 64'h0);
        send_request(24'h000000, '1, '1);
        send_request(24'hFFFFFF, '1, '1);
        send_request(24'h000001, 64'h0, 64'h0);
        send_request(24'h000053, 64'h0, 64'h0);
        send_request(24'h808080, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        send_request(24'h5A5A00, rand64(), rand64());
        send_request(24'hAA55FF, rand64(), rand64());
        for (int v = 0; v < 8; v++)
            send_request(24'h010101 << v, rand64(), rand64());
        hold_off(1);
        while (pending != 0)
            @(posedge clk);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                send_request(24'($urandom()), rand64(), rand64());
                sent++;
            end
            if (sent > N_RANDOM / 2 && sent < N_RANDOM / 2 + 41)
            begin
                hold_off(1);
                while (pending != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
                hold_off($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
design/msbox_pkg.sv
design/msbox_isw_stage.sv
design/masked_aes_sbox.sv
tb/sv/sbox_checker.sv
tb/sv/tb.sv
